// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  // transaction kinds
  typedef enum logic [1:0] {
    MODE_ACK     = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_SEND    = 2'd3
  } tcw_mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DSTART,
    ST_DWAIT,
    ST_PUSH
  } tcw_state_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 3'd3;

  // register reset values
  localparam logic [15:0] SEG_SIZE_RST  = 16'd1400;
  localparam logic [31:0] INIT_WIN_RST  = 32'd1400;
  localparam logic [31:0] INIT_THR_RST  = 32'd65536;
  localparam logic [31:0] START_SEQ_RST = 32'd0;

  // duplicate acks that enter fast recovery
  localparam logic [7:0] DUP_THRESHOLD = 8'd3;
  localparam logic [7:0] DUP_MAX       = 8'hFF;

  // divider step count
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

  typedef struct packed {
    tcw_mode_t   mode;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] write_len;
  } tcw_in_item_t;

  typedef struct packed {
    logic [31:0] send_seq;
    logic [15:0] send_len;
    logic [31:0] cwnd_now;
    logic [31:0] thresh_now;
    logic [7:0]  dup_count;
    logic        rewound;
  } tcw_out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tcw_div_stat_t;

  // 32-bit add saturating at all ones
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== src/tcw_if.sv =====
// input event channel
interface tcw_in_if;
  logic                  valid;
  logic                  ready;
  tcw_pkg::tcw_in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface tcw_out_if;
  logic                   valid;
  logic                   ready;
  tcw_pkg::tcw_out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tcw_div.sv =====
module tcw_div import tcw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [31:0]   divisor,
  output tcw_div_stat_t stat,
  output logic [31:0]   quotient
);

  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [31:0]          dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [32:0]          trial;
  logic [32:0]          diff;

  // one restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = diff[32] ? trial[31:0] : diff[31:0];
      quo_nxt = {quo_r[30:0], ~diff[32]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== src/tcp_congestion_window_control_top.sv =====
// channel  | direction | payload
// in_ch    | sink      | mode, ack_number, peer_window, write_len
// out_ch   | source    | send_seq, send_len, cwnd_now, thresh_now, dup_count, rewound
// cfg_*    | write     | cfg_index selects register, cfg_data its value
//
// A plain transaction moves from idle through execute to push, where its result is
// registered onto out_ch; the next can be accepted once the sequencer is back in idle.
// Congestion avoidance growth runs MSS*MSS/cwnd through the radix-2 divider,
// one quotient bit per cycle, via the divider start and wait states before push.
// rst_n is synchronous and the block is ready right after reset; in_ch.ready is high
// only while idle, and a result held by out_ch stalls the next one in its push state.
module tcp_congestion_window_control_top import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tcw_in_if.sink               in_ch,
  tcw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  tcw_state_t    state_r, state_nxt;
  tcw_in_item_t  item_r;
  tcw_out_item_t out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [15:0] seg_size_r, seg_size_nxt;
  logic [31:0] init_win_r, init_win_nxt;
  logic [31:0] init_thr_r, init_thr_nxt;
  logic [31:0] start_seq_r, start_seq_nxt;

  logic [31:0] cwnd_r, cwnd_nxt;
  logic [31:0] ssthresh_r, ssthresh_nxt;
  logic [7:0]  dup_r, dup_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [31:0] sent_r, sent_nxt;
  logic [31:0] written_r, written_nxt;
  logic [15:0] peerwin_r, peerwin_nxt;

  logic [31:0] res_seq_r, res_seq_nxt;
  logic [15:0] res_len_r, res_len_nxt;
  logic        res_rew_r, res_rew_nxt;
  logic [31:0] prod_r, prod_nxt;

  logic          in_fire;
  logic          div_start;
  tcw_div_stat_t div_stat;
  logic [31:0]   div_quo;

  logic [31:0] acked_w;
  logic [31:0] ahead_w;
  logic        is_dup;
  logic        is_new;
  logic [7:0]  dup_inc;
  logic [31:0] half_cwnd;
  logic [17:0] seg3;
  logic        hold_w;
  logic [31:0] pend_raw;
  logic [31:0] pend_w;
  logic [31:0] min_cp;
  logic [15:0] grant_w;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // ack classification by serial compare
  assign acked_w = item_r.ack_number - 32'd1;
  assign ahead_w = acked_w - acked_r;
  assign is_dup  = (ahead_w == 32'd0);
  assign is_new  = !is_dup && !ahead_w[31];
  assign dup_inc = (dup_r != DUP_MAX) ? dup_r + 8'd1 : dup_r;

  // fast recovery entry terms
  assign half_cwnd = {1'b0, cwnd_r[31:1]};
  assign seg3      = {2'b00, seg_size_r} + {1'b0, seg_size_r, 1'b0};

  // send budget
  assign hold_w   = (dup_r != 8'd0) && (dup_r < DUP_THRESHOLD) && (peerwin_r != 16'd0);
  assign pend_raw = written_r - sent_r;
  assign pend_w   = pend_raw[31] ? 32'd0 : pend_raw;
  assign min_cp   = (cwnd_r < pend_w) ? cwnd_r : pend_w;

  always_comb begin
    if (hold_w || min_cp == 32'd0) begin
      grant_w = 16'd0;
    end else if (peerwin_r == 16'd0) begin
      grant_w = 16'd1;
    end else if (min_cp > {16'd0, peerwin_r}) begin
      grant_w = peerwin_r;
    end else begin
      grant_w = min_cp[15:0];
    end
  end

  // sequencer, state update and configuration writes
  always_comb begin
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    seg_size_nxt  = seg_size_r;
    init_win_nxt  = init_win_r;
    init_thr_nxt  = init_thr_r;
    start_seq_nxt = start_seq_r;
    cwnd_nxt      = cwnd_r;
    ssthresh_nxt  = ssthresh_r;
    dup_nxt       = dup_r;
    acked_nxt     = acked_r;
    sent_nxt      = sent_r;
    written_nxt   = written_r;
    peerwin_nxt   = peerwin_r;
    res_seq_nxt   = res_seq_r;
    res_len_nxt   = res_len_r;
    res_rew_nxt   = res_rew_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt   = ST_PUSH;
        res_len_nxt = 16'd0;
        res_rew_nxt = 1'b0;
        case (item_r.mode)
          MODE_ACK: begin
            peerwin_nxt = item_r.peer_window;
            if (is_new) begin
              dup_nxt   = 8'd0;
              acked_nxt = acked_w;
              if (dup_r >= DUP_THRESHOLD) begin
                cwnd_nxt = ssthresh_r;
              end else if (cwnd_r <= ssthresh_r) begin
                cwnd_nxt = sat_add(cwnd_r, {16'd0, seg_size_r});
              end else begin
                prod_nxt  = 32'(seg_size_r) * 32'(seg_size_r);
                state_nxt = ST_DSTART;
              end
            end else if (is_dup) begin
              dup_nxt = dup_inc;
              if (dup_inc == DUP_THRESHOLD) begin
                ssthresh_nxt = half_cwnd;
                cwnd_nxt     = sat_add(half_cwnd, {14'd0, seg3});
                sent_nxt     = acked_r;
                res_rew_nxt  = 1'b1;
              end else if (dup_inc > DUP_THRESHOLD) begin
                cwnd_nxt = sat_add(cwnd_r, {16'd0, seg_size_r});
              end
            end
          end
          MODE_TIMEOUT: begin
            dup_nxt      = 8'd0;
            ssthresh_nxt = half_cwnd;
            cwnd_nxt     = {16'd0, seg_size_r};
            sent_nxt     = acked_r;
            res_rew_nxt  = 1'b1;
          end
          MODE_WRITE: begin
            written_nxt = written_r + {16'd0, item_r.write_len};
          end
          MODE_SEND: begin
            sent_nxt    = sent_r + {16'd0, grant_w};
            res_len_nxt = grant_w;
          end
          default: ;
        endcase
        // send opportunity reports the first granted byte, others the new pointer
        res_seq_nxt = (item_r.mode == MODE_SEND) ? sent_r + 32'd1 : sent_nxt + 32'd1;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_stat.done) begin
          cwnd_nxt  = sat_add(cwnd_r, div_quo);
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt.send_seq   = res_seq_r;
          out_data_nxt.send_len   = res_len_r;
          out_data_nxt.cwnd_now   = cwnd_r;
          out_data_nxt.thresh_now = ssthresh_r;
          out_data_nxt.dup_count  = dup_r;
          out_data_nxt.rewound    = res_rew_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register writes, expected only while no transaction is in flight
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEG_SIZE: seg_size_nxt = cfg_data[15:0];
        CFG_INIT_WIN: begin
          init_win_nxt = cfg_data;
          cwnd_nxt     = cfg_data;
        end
        CFG_INIT_THR: begin
          init_thr_nxt = cfg_data;
          ssthresh_nxt = cfg_data;
        end
        CFG_START_SEQ: begin
          start_seq_nxt = cfg_data;
          acked_nxt     = cfg_data;
          sent_nxt      = cfg_data;
          written_nxt   = cfg_data;
        end
        default: ;
      endcase
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seg_size_r  <= SEG_SIZE_RST;
      init_win_r  <= INIT_WIN_RST;
      init_thr_r  <= INIT_THR_RST;
      start_seq_r <= START_SEQ_RST;
      cwnd_r      <= INIT_WIN_RST;
      ssthresh_r  <= INIT_THR_RST;
      dup_r       <= 8'd0;
      acked_r     <= START_SEQ_RST;
      sent_r      <= START_SEQ_RST;
      written_r   <= START_SEQ_RST;
      peerwin_r   <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seg_size_r  <= seg_size_nxt;
      init_win_r  <= init_win_nxt;
      init_thr_r  <= init_thr_nxt;
      start_seq_r <= start_seq_nxt;
      cwnd_r      <= cwnd_nxt;
      ssthresh_r  <= ssthresh_nxt;
      dup_r       <= dup_nxt;
      acked_r     <= acked_nxt;
      sent_r      <= sent_nxt;
      written_r   <= written_nxt;
      peerwin_r   <= peerwin_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_ch.data;
    end
    out_data_r <= out_data_nxt;
    res_seq_r  <= res_seq_nxt;
    res_len_r  <= res_len_nxt;
    res_rew_r  <= res_rew_nxt;
    prod_r     <= prod_nxt;
  end

  // divider for congestion avoidance growth
  tcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (cwnd_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // accepted transaction always moves into execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted transaction did not enter execute");

  // divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DWAIT)
    else $error("divider busy outside wait state");

  // a rewind never comes with a send grant
  a_rew_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rewound |-> out_data_r.send_len == 16'd0)
    else $error("rewound result carries a send grant");

  // a new result is loaded only when the output slot is free
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH && out_valid_r && !out_ch.ready |=> state_r == ST_PUSH)
    else $error("result overwritten while waiting");

endmodule

// ===== tb/tcp_congestion_window_control_top_tb.sv =====
`timescale 1ns / 100ps

module tcp_congestion_window_control_top_tb;
  import tcw_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 96;
  localparam int unsigned STORM_LEN       = 260;
  localparam int unsigned PRESSURE_AT     = 350;
  localparam int unsigned PRESSURE_CYCLES = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 3'd5;

  // one line of the directed script: a register write or a transaction
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
    tcw_in_item_t         ev;
    logic                 typed;
    tcw_out_item_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  tcp_congestion_window_control_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // window engine state as the testbench sees it
  logic [15:0] reg_seg;
  logic [31:0] win_cwnd;
  logic [31:0] win_ssthresh;
  logic [7:0]  win_dups;
  logic [15:0] win_peer;
  logic [31:0] ptr_acked;
  logic [31:0] ptr_sent;
  logic [31:0] ptr_written;

  tcw_out_item_t pending_results[$];
  stim_row_t     script[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  bit            idle_on = 1'b1;

  function automatic logic [31:0] sum_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // advance the window state by one transaction and return its result
  function automatic tcw_out_item_t step_window(input tcw_in_item_t ev);
    tcw_out_item_t res;
    logic [31:0] acked, ahead, pend, grant, seg32, incr;
    logic hold;
    res = '0;
    grant = '0;
    seg32 = {16'd0, reg_seg};
    case (ev.mode)
      MODE_ACK: begin
        acked = ev.ack_number - 32'd1;
        ahead = acked - ptr_acked;
        win_peer = ev.peer_window;
        if (ahead != 0 && !ahead[31]) begin
          // new data acknowledged
          if (win_dups >= DUP_THRESHOLD) begin
            win_cwnd = win_ssthresh;
          end else if (win_cwnd <= win_ssthresh) begin
            win_cwnd = sum_clamped(win_cwnd, seg32);
          end else begin
            incr = (seg32 * seg32) / win_cwnd;
            win_cwnd = sum_clamped(win_cwnd, incr);
          end
          win_dups = '0;
          ptr_acked = acked;
        end else if (ahead == 0) begin
          // duplicate ack
          if (win_dups != DUP_MAX) win_dups = win_dups + 8'd1;
          if (win_dups == DUP_THRESHOLD) begin
            win_ssthresh = win_cwnd >> 1;
            win_cwnd = sum_clamped(win_ssthresh, seg32 * 3);
            ptr_sent = ptr_acked;
            res.rewound = 1'b1;
          end else if (win_dups > DUP_THRESHOLD) begin
            win_cwnd = sum_clamped(win_cwnd, seg32);
          end
        end
      end
      MODE_TIMEOUT: begin
        win_dups = '0;
        win_ssthresh = win_cwnd >> 1;
        win_cwnd = seg32;
        ptr_sent = ptr_acked;
        res.rewound = 1'b1;
      end
      MODE_WRITE: ptr_written = ptr_written + {16'd0, ev.write_len};
      default: ;
    endcase
    res.send_seq = ptr_sent + 32'd1;
    // send budget, held back while duplicates are below the threshold and the peer window is open
    if (ev.mode == MODE_SEND) begin
      hold = win_dups != 0 && win_dups < DUP_THRESHOLD && win_peer != 0;
      if (!hold) begin
        pend = ptr_written - ptr_sent;
        if (pend[31]) pend = '0;
        grant = (win_cwnd < pend) ? win_cwnd : pend;
        if (grant != 0 && win_peer == 0) grant = 32'd1;
        else if (grant > win_peer) grant = {16'd0, win_peer};
      end
      ptr_sent = ptr_sent + grant;
    end
    res.send_len   = grant[15:0];
    res.cwnd_now   = win_cwnd;
    res.thresh_now = win_ssthresh;
    res.dup_count  = win_dups;
    return res;
  endfunction

  // well-formed traffic drawn around the current pointers, with some noise
  function automatic tcw_in_item_t next_traffic();
    tcw_in_item_t ev;
    logic [31:0] span;
    int unsigned pick, reach;
    ev.mode = MODE_SEND;
    ev.ack_number = $urandom;
    ev.peer_window = 16'($urandom);
    ev.write_len = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      case ($urandom_range(0, 9))
        0: ev.peer_window = '0;
        1: ev.peer_window = 16'($urandom_range(1, 16));
        2, 3: ev.peer_window = 16'($urandom);
        default: ev.peer_window = 16'($urandom_range(16384, 65535));
      endcase
    end
    if (pick < 20) begin
      ev.mode = MODE_WRITE;
      if ($urandom_range(0, 7) != 0) ev.write_len = 16'($urandom_range(0, 4000));
    end else if (pick < 45) begin
      ev.mode = MODE_SEND;
    end else if (pick < 65) begin
      // ack something in flight, or run past the sent pointer
      ev.mode = MODE_ACK;
      span = ptr_sent - ptr_acked;
      if (span != 0 && !span[31] && $urandom_range(0, 5) != 0) begin
        reach = (span > 20000) ? 20000 : span;
        ev.ack_number = ptr_acked + 32'd1 + $urandom_range(1, reach);
      end else begin
        ev.ack_number = ptr_acked + 32'd1 + $urandom_range(1, 3000);
      end
    end else if (pick < 85) begin
      ev.mode = MODE_ACK;
      ev.ack_number = ptr_acked + 32'd1;
    end else if (pick < 90) begin
      ev.mode = MODE_TIMEOUT;
    end else begin
      ev.mode = tcw_mode_t'($urandom_range(0, 3));
    end
    return ev;
  endfunction

  task automatic add_event(input tcw_mode_t m, input logic [31:0] ackn,
                           input logic [15:0] pwin, input logic [15:0] wlen,
                           input logic typed, input tcw_out_item_t want);
    stim_row_t r;
    r = '0;
    r.ev.mode = m;
    r.ev.ack_number = ackn;
    r.ev.peer_window = pwin;
    r.ev.write_len = wlen;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    script.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // offer one transaction and log its expected result once it is taken
  task automatic send_event(input tcw_in_item_t ev, input logic typed,
                            input tcw_out_item_t want);
    tcw_out_item_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    do @(posedge clk); while (!in_ch.ready);
    predicted = step_window(ev);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // let every outstanding result drain before touching registers
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SEG_SIZE:  reg_seg = val[15:0];
      CFG_INIT_WIN:  win_cwnd = val;
      CFG_INIT_THR:  win_ssthresh = val;
      CFG_START_SEQ: begin
        ptr_acked = val;
        ptr_sent = val;
        ptr_written = val;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off, field by field compare
  initial begin : result_sink
    tcw_out_item_t got, want;
    int unsigned stall_left, taken;
    bit held;
    stall_left = 0;
    taken = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        taken++;
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result, send_seq", got.send_seq, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.send_seq !== want.send_seq)
            flag_mismatch("send_seq", got.send_seq, want.send_seq);
          if (got.send_len !== want.send_len)
            flag_mismatch("send_len", {16'd0, got.send_len}, {16'd0, want.send_len});
          if (got.cwnd_now !== want.cwnd_now)
            flag_mismatch("cwnd_now", got.cwnd_now, want.cwnd_now);
          if (got.thresh_now !== want.thresh_now)
            flag_mismatch("thresh_now", got.thresh_now, want.thresh_now);
          if (got.dup_count !== want.dup_count)
            flag_mismatch("dup_count", {24'd0, got.dup_count}, {24'd0, want.dup_count});
          if (got.rewound !== want.rewound)
            flag_mismatch("rewound", {31'd0, got.rewound}, {31'd0, want.rewound});
        end
      end
      if (taken == PRESSURE_AT && !held) begin
        stall_left = PRESSURE_CYCLES;
        held = 1'b1;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // no transaction on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    tcw_in_item_t ev;
    logic [31:0] seg_v, win_v, thr_v, start_v;
    int i, p, k;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;

    reg_seg      = SEG_SIZE_RST;
    win_cwnd     = INIT_WIN_RST;
    win_ssthresh = INIT_THR_RST;
    win_dups     = '0;
    win_peer     = '0;
    ptr_acked    = START_SEQ_RST;
    ptr_sent     = START_SEQ_RST;
    ptr_written  = START_SEQ_RST;

    // directed script; expected fields are {seq, len, cwnd, thresh, dups, rewound}
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b1,
              {32'd1, 16'd0, 32'd1400, 32'd65536, 8'd0, 1'b0});
    add_event(MODE_WRITE, 32'd0, 16'd0, 16'hFFFF, 1'b1,
              {32'd1, 16'd0, 32'd1400, 32'd65536, 8'd0, 1'b0});
    // zero peer window: one-byte probe
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b1,
              {32'd1, 16'd1, 32'd1400, 32'd65536, 8'd0, 1'b0});
    add_event(MODE_ACK, 32'd2, 16'hFFFF, 16'd0, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    // duplicates: hold, fast recovery entry with rewind, then inflation
    add_event(MODE_ACK, 32'd2, 16'd30000, 16'd0, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_ACK, 32'd2, 16'd30000, 16'd0, 1'b0, '0);
    add_event(MODE_ACK, 32'd2, 16'd30000, 16'd0, 1'b0, '0);
    add_event(MODE_ACK, 32'd2, 16'd30000, 16'd0, 1'b0, '0);
    // recovery exit, then a stale ack that only stores a zero window
    add_event(MODE_ACK, 32'd3000, 16'hFFFF, 16'd0, 1'b0, '0);
    add_event(MODE_ACK, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_TIMEOUT, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    // congestion avoidance growth goes through the divider
    add_event(MODE_ACK, 32'd4001, 16'd1000, 16'd0, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b0, '0);
    // register extremes, unknown index ignored
    add_cfg(CFG_SEG_SIZE, 32'h0000_FFFF);
    add_cfg(CFG_INIT_WIN, 32'hFFFF_FFFF);
    add_cfg(CFG_INIT_THR, 32'hFFFF_FFFF);
    add_cfg(CFG_START_SEQ, 32'hFFFF_FFF0);
    add_cfg(CFG_UNKNOWN, 32'h0000_0000);
    // window saturates at all ones
    add_event(MODE_ACK, 32'hFFFF_FFF2, 16'hFFFF, 16'd0, 1'b1,
              {32'hFFFF_FFF1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0});
    // pointers wrap around zero
    add_event(MODE_WRITE, 32'd0, 16'd0, 16'h0040, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_ACK, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_SEND, 32'd0, 16'd0, 16'd0, 1'b0, '0);
    add_event(MODE_TIMEOUT, 32'd0, 16'd0, 16'd0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.is_cfg) begin
        quiesce();
        write_reg(row.idx, row.val);
      end else begin
        send_event(row.ev, row.typed, row.want);
      end
    end

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      quiesce();
      seg_v   = $urandom_range(1, 65535);
      win_v   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
      thr_v   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
      start_v = $urandom;
      idle_on = 1'b1;
      case (p)
        0: begin
          seg_v = 32'd1400;
          win_v = 32'd1400;
          thr_v = 32'd8000;
        end
        1: begin
          seg_v = 32'd1;
          win_v = 32'd1;
          thr_v = 32'd0;
          start_v = 32'd0;
        end
        2: begin
          seg_v = 32'd65535;
          win_v = 32'hFFFF_FFFF;
          thr_v = 32'hFFFF_FFFF;
          start_v = 32'hFFFF_FF00;
        end
        3: begin
          seg_v = 32'd0;
          win_v = 32'd0;
          thr_v = 32'd0;
        end
        4: begin
          seg_v = 32'd536;
          win_v = 32'd1072;
          thr_v = 32'd4000;
          idle_on = 1'b0;
        end
        7: idle_on = 1'b0;
        default: ;
      endcase
      write_reg(CFG_SEG_SIZE, seg_v);
      write_reg(CFG_INIT_WIN, win_v);
      write_reg(CFG_INIT_THR, thr_v);
      write_reg(CFG_START_SEQ, start_v);
      if (p == 6) write_reg(CFG_UNKNOWN, $urandom);

      // long run of duplicates drives the count into saturation
      if (p == 5) begin
        for (k = 0; k < STORM_LEN; k++) begin
          ev = next_traffic();
          ev.mode = MODE_ACK;
          ev.ack_number = ptr_acked + 32'd1;
          send_event(ev, 1'b0, '0);
        end
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_event(next_traffic(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
